// ===== hdl/mrm_pkg.sv =====
package mrm_pkg;

  typedef enum logic [1:0] {
    KIND_ADD_SUB = 2'd0,
    KIND_ADD_OBJ = 2'd1,
    KIND_READ    = 2'd2,
    KIND_WRITE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_SUB_ADDED = 3'd0,
    STATUS_OBJ_ADDED = 3'd1,
    STATUS_GRANTED   = 3'd2,
    STATUS_DENIED    = 3'd3,
    STATUS_BAD       = 3'd4
  } status_e;

  localparam logic [1:0] LabelBad = 2'd3;
  localparam int unsigned KeyPortBits = 16;

  typedef struct packed {
    kind_e                   kind;
    logic [KeyPortBits-1:0]  subject_key;
    logic [KeyPortBits-1:0]  object_key;
    logic [1:0]              label;
    logic signed [31:0]      write_value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage

// ===== hdl/mls_reference_monitor_core.sv =====
// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+------------------------
// request | in        | in_valid_i / in_ready_o    | in_data_i  (req_t)
// result  | out       | out_valid_o / out_ready_i  | out_data_o (rsp_t)
//
// One word per cycle: tables are matched in parallel on the request word and
// the result is registered, so a result appears in the cycle after acceptance.
// Throughput is set by the single result register; in_ready_o drops only
// while that register holds a word that out_ready_i does not take.
// rst_ni clears the entry counts and the result valid; table contents are
// reloaded by add requests.
module mls_reference_monitor_core
  import mrm_pkg::*;
#(
  parameter int unsigned MAX_SUBJECTS = 16,
  parameter int unsigned MAX_OBJECTS  = 16,
  parameter int unsigned KEY_BITS     = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned KW   = (KEY_BITS < KeyPortBits) ? KEY_BITS : KeyPortBits;
  localparam int unsigned SCW  = $clog2(MAX_SUBJECTS + 1);
  localparam int unsigned OCW  = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned SIW  = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
  localparam int unsigned OIW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  logic [KW-1:0]      s_key_q [MAX_SUBJECTS];
  logic [1:0]         s_lab_q [MAX_SUBJECTS];
  logic [KW-1:0]      o_key_q [MAX_OBJECTS];
  logic [1:0]         o_lab_q [MAX_OBJECTS];
  logic signed [31:0] o_val_q [MAX_OBJECTS];
  logic [SCW-1:0]     s_cnt_q, s_cnt_d;
  logic [OCW-1:0]     o_cnt_q, o_cnt_d;

  logic               out_valid_q, out_valid_d;
  rsp_t               out_data_q, out_data_d;

  logic [KW-1:0]      req_skey, req_okey;
  logic [MAX_SUBJECTS-1:0] s_hit;
  logic [MAX_OBJECTS-1:0]  o_hit;
  logic               s_found, o_found, s_full, o_full;
  logic [1:0]         s_lab, o_lab;
  logic signed [31:0] o_val;
  logic               fire, label_ok;
  logic               add_sub, add_obj, do_write;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign req_skey = in_data_i.subject_key[KW-1:0];
  assign req_okey = in_data_i.object_key[KW-1:0];
  assign s_full   = (s_cnt_q == SCW'(MAX_SUBJECTS));
  assign o_full   = (o_cnt_q == OCW'(MAX_OBJECTS));

  always_comb begin
    s_lab = '0;
    for (int i = 0; i < MAX_SUBJECTS; i++) begin
      s_hit[i] = (SCW'(i) < s_cnt_q) && (s_key_q[i] == req_skey);
      s_lab    = s_lab | (s_hit[i] ? s_lab_q[i] : 2'd0);
    end
  end

  always_comb begin
    o_lab = '0;
    o_val = '0;
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      o_hit[i] = (OCW'(i) < o_cnt_q) && (o_key_q[i] == req_okey);
      o_lab    = o_lab | (o_hit[i] ? o_lab_q[i] : 2'd0);
      o_val    = o_val | (o_hit[i] ? o_val_q[i] : 32'sd0);
    end
  end

  assign s_found = |s_hit;
  assign o_found = |o_hit;

  always_comb begin
    out_data_d.status     = STATUS_BAD;
    out_data_d.read_value = '0;
    add_sub  = 1'b0;
    add_obj  = 1'b0;
    do_write = 1'b0;
    label_ok = (s_lab != LabelBad) && (o_lab != LabelBad) &&
               ((in_data_i.kind == KIND_READ) ? (s_lab >= o_lab) : (s_lab <= o_lab));
    unique case (in_data_i.kind)
      KIND_ADD_SUB: begin
        if (!s_found && !s_full) begin
          add_sub = 1'b1;
          out_data_d.status = STATUS_SUB_ADDED;
        end
      end
      KIND_ADD_OBJ: begin
        if (!o_found && !o_full) begin
          add_obj = 1'b1;
          out_data_d.status = STATUS_OBJ_ADDED;
        end
      end
      KIND_READ, KIND_WRITE: begin
        if (s_found && o_found) begin
          if (!label_ok) begin
            out_data_d.status = STATUS_DENIED;
          end else begin
            out_data_d.status = STATUS_GRANTED;
            if (in_data_i.kind == KIND_READ) begin
              out_data_d.read_value = o_val;
            end else begin
              do_write = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    s_cnt_d     = s_cnt_q;
    o_cnt_d     = o_cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      if (add_sub) begin
        s_cnt_d = s_cnt_q + SCW'(1);
      end
      if (add_obj) begin
        o_cnt_d = o_cnt_q + OCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_cnt_q     <= '0;
      o_cnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_cnt_q     <= s_cnt_d;
      o_cnt_q     <= o_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
      if (add_sub) begin
        s_key_q[s_cnt_q[SIW-1:0]] <= req_skey;
        s_lab_q[s_cnt_q[SIW-1:0]] <= in_data_i.label;
      end
      if (add_obj) begin
        o_key_q[o_cnt_q[OIW-1:0]] <= req_okey;
        o_lab_q[o_cnt_q[OIW-1:0]] <= in_data_i.label;
        o_val_q[o_cnt_q[OIW-1:0]] <= '0;
      end
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        if (do_write && o_hit[i]) begin
          o_val_q[i] <= in_data_i.write_value;
        end
      end
    end
  end

  // keys are unique, so at most one entry of each table may match
  a_s_unique: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(s_hit))
    else $error("subject table matched more than one entry");
  a_o_unique: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(o_hit))
    else $error("object table matched more than one entry");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_cnt_q <= SCW'(MAX_SUBJECTS)) && (o_cnt_q <= OCW'(MAX_OBJECTS)))
    else $error("table count beyond capacity");
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> out_valid_o)
    else $error("accepted word produced no result");
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/sv/tb_mls_reference_monitor_core.sv =====
`timescale 1ns / 100ps

module tb_mls_reference_monitor_core;
  import mrm_pkg::*;

  localparam int MaxSub = 16;
  localparam int MaxObj = 16;
  localparam int RandWords = 1925;
  localparam int HoldAt = 700;
  localparam int LongHold = 250;
  localparam logic [1:0] LblLow = 2'd0;
  localparam logic [1:0] LblMed = 2'd1;
  localparam logic [1:0] LblHigh = 2'd2;

  typedef struct {
    req_t word;
    bit   drain;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  job_t pending[$];
  rsp_t access_results[$];
  logic [15:0] sub_pool[$];
  logic [15:0] obj_pool[$];

  logic [15:0] sub_keys[MaxSub];
  logic [1:0] sub_lbl[MaxSub];
  logic signed [31:0] sub_tmp[MaxSub];
  int sub_n = 0;
  logic [15:0] obj_keys[MaxObj];
  logic [1:0] obj_lbl[MaxObj];
  logic signed [31:0] obj_val[MaxObj];
  int obj_n = 0;

  bit req_fire = 1'b0;
  bit rsp_fire = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int words_sent = 0;
  int rsp_seen = 0;
  int errs = 0;
  int status_hits[5] = '{default: 0};

  mls_reference_monitor_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int find_key(input logic [15:0] keys[16], input int n,
                                  input logic [15:0] k);
    for (int i = 0; i < n; i++) begin
      if (keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t predict_access(req_t w);
    rsp_t r;
    int si;
    int oi;
    bit permit;
    r.status = STATUS_BAD;
    r.read_value = '0;
    case (w.kind)
      KIND_ADD_SUB: begin
        if (find_key(sub_keys, sub_n, w.subject_key) < 0 && sub_n < MaxSub) begin
          sub_keys[sub_n] = w.subject_key;
          sub_lbl[sub_n] = w.label;
          sub_tmp[sub_n] = '0;
          sub_n++;
          r.status = STATUS_SUB_ADDED;
        end
      end
      KIND_ADD_OBJ: begin
        if (find_key(obj_keys, obj_n, w.object_key) < 0 && obj_n < MaxObj) begin
          obj_keys[obj_n] = w.object_key;
          obj_lbl[obj_n] = w.label;
          obj_val[obj_n] = '0;
          obj_n++;
          r.status = STATUS_OBJ_ADDED;
        end
      end
      default: begin
        si = find_key(sub_keys, sub_n, w.subject_key);
        oi = find_key(obj_keys, obj_n, w.object_key);
        if (si >= 0 && oi >= 0) begin
          permit = sub_lbl[si] != LabelBad && obj_lbl[oi] != LabelBad &&
                   (w.kind == KIND_READ ? sub_lbl[si] >= obj_lbl[oi]
                                        : sub_lbl[si] <= obj_lbl[oi]);
          if (!permit) begin
            r.status = STATUS_DENIED;
          end else begin
            r.status = STATUS_GRANTED;
            if (w.kind == KIND_READ) begin
              sub_tmp[si] = obj_val[oi];
              r.read_value = obj_val[oi];
            end else begin
              obj_val[oi] = w.write_value;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic bit quiet_span(int n);
    return (n % 300) < 50;
  endfunction

  task automatic push_word(kind_e k, logic [15:0] sk, logic [15:0] okey,
                           logic [1:0] lb, logic [31:0] v, bit drain);
    job_t j;
    j.word.kind = k;
    j.word.subject_key = sk;
    j.word.object_key = okey;
    j.word.label = lb;
    j.word.write_value = v;
    j.drain = drain;
    pending.push_back(j);
  endtask

  function automatic logic [15:0] pick_key(ref logic [15:0] pool[$]);
    if (pool.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // request driver
  always @(negedge clk_i) begin
    logic nv;
    if (rst_ni) begin
      nv = in_valid_i && !req_fire;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && access_results.size() > 0)) begin
          in_data_i <= pending[0].word;
          pending.pop_front();
          nv = 1'b1;
          words_sent++;
          gap_left = quiet_span(words_sent) ? 0 : $urandom_range(0, 10);
        end
      end
      in_valid_i <= nv;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_fire) begin
        stall_left = quiet_span(rsp_seen) ? 0 : $urandom_range(0, 10);
        if (rsp_seen == HoldAt) stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rsp_seen++;
        if (out_data_o.status < 5) status_hits[out_data_o.status]++;
        if (access_results.size() == 0) begin
          $error("result word with nothing expected: status %0d", out_data_o.status);
          errs++;
        end else begin
          want = access_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            errs++;
          end
          if (out_data_o.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   out_data_o.read_value);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_o) access_results.push_back(predict_access(in_data_i));
      req_fire <= in_valid_i && in_ready_o;
      rsp_fire <= out_valid_o && out_ready_i;
    end
  end

  initial begin
    #2000000;
    $display("timed out with %0d words pending", access_results.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int r;
    kind_e k;
    logic [15:0] key;
    // directed words, starting with empty tables
    push_word(KIND_READ, 16'h0000, 16'h0000, LblLow, 32'h0, 1'b0);
    push_word(KIND_WRITE, 16'h0000, 16'h0000, LblLow, 32'h1, 1'b0);
    push_word(KIND_ADD_SUB, 16'h0000, 16'hAAAA, LblLow, 32'hFFFF_FFFF, 1'b0);
    push_word(KIND_ADD_SUB, 16'hFFFF, 16'h0000, LblHigh, 32'h0, 1'b0);
    push_word(KIND_ADD_SUB, 16'h1234, 16'h0000, LabelBad, 32'h0, 1'b0);
    push_word(KIND_ADD_SUB, 16'h0001, 16'h0000, LblMed, 32'h0, 1'b0);
    push_word(KIND_ADD_SUB, 16'h0000, 16'h0000, LblHigh, 32'h0, 1'b0);
    push_word(KIND_READ, 16'h0000, 16'h0000, LblLow, 32'h0, 1'b0);
    push_word(KIND_ADD_OBJ, 16'h5555, 16'h0000, LblLow, 32'h8000_0000, 1'b0);
    push_word(KIND_ADD_OBJ, 16'h0000, 16'hFFFF, LblHigh, 32'h0, 1'b0);
    push_word(KIND_ADD_OBJ, 16'h0000, 16'h8000, LabelBad, 32'h0, 1'b0);
    push_word(KIND_ADD_OBJ, 16'h0000, 16'h00FF, LblMed, 32'h0, 1'b0);
    push_word(KIND_ADD_OBJ, 16'h0000, 16'hFFFF, LblLow, 32'h0, 1'b0);
    push_word(KIND_WRITE, 16'h0000, 16'hFFFF, LblLow, 32'h7FFF_FFFF, 1'b0);
    push_word(KIND_WRITE, 16'h0000, 16'h0000, LblLow, 32'h8000_0000, 1'b0);
    push_word(KIND_READ, 16'hFFFF, 16'hFFFF, LblLow, 32'h1234_5678, 1'b0);
    push_word(KIND_READ, 16'h0000, 16'hFFFF, LblLow, 32'h0, 1'b0);
    push_word(KIND_WRITE, 16'hFFFF, 16'h0000, LblHigh, 32'h5, 1'b0);
    push_word(KIND_READ, 16'h1234, 16'h0000, LblLow, 32'h0, 1'b0);
    push_word(KIND_WRITE, 16'h0000, 16'h8000, LblLow, 32'h6, 1'b0);
    push_word(KIND_READ, 16'h0001, 16'h0000, LblMed, 32'h0, 1'b0);
    push_word(KIND_READ, 16'h5555, 16'h0000, LblLow, 32'h0, 1'b0);
    push_word(KIND_WRITE, 16'h0000, 16'h7777, LblLow, 32'h0, 1'b0);
    push_word(KIND_WRITE, 16'h0001, 16'h00FF, LabelBad, 32'hFFFF_FFFF, 1'b0);
    push_word(KIND_READ, 16'h0001, 16'h00FF, LblHigh, 32'h0, 1'b0);
    sub_pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0001};
    obj_pool = '{16'h0000, 16'hFFFF, 16'h8000, 16'h00FF};

    for (int i = 0; i < RandWords; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        key = ($urandom_range(0, 3) == 0) ? pick_key(sub_pool) : 16'($urandom);
        if (sub_pool.size() < MaxSub) sub_pool.push_back(key);
        push_word(KIND_ADD_SUB, key, 16'($urandom), 2'($urandom), $urandom,
                  i % 400 == 399);
      end else if (r < 16) begin
        key = ($urandom_range(0, 3) == 0) ? pick_key(obj_pool) : 16'($urandom);
        if (obj_pool.size() < MaxObj) obj_pool.push_back(key);
        push_word(KIND_ADD_OBJ, 16'($urandom), key, 2'($urandom), $urandom,
                  i % 400 == 399);
      end else begin
        k = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
        push_word(k, pick_key(sub_pool), pick_key(obj_pool), 2'($urandom), $urandom,
                  i % 400 == 399);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() > 0 || in_valid_i || access_results.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d request words, %0d results checked, %0d mismatches", words_sent,
             rsp_seen, errs);
    $display("added %0d/%0d, granted %0d, denied %0d, rejected %0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errs == 0 && access_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
